@@ sv/mpe_pkg.sv @@
package mpe_pkg;

   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int ELEM_WIDTH_DEFAULT = 16;

   localparam int MODE_W     = 2;
   localparam int IDX_W      = 3;
   localparam int VALUE_W    = 16;
   localparam int SUM_W      = 35;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 4'd8;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } token_type;

endpackage

@@ sv/mpe_if.sv @@
interface mpe_req_if;
   logic                                valid;
   logic                                ready;
   logic [mpe_pkg::MODE_W-1:0]          mode;
   logic [mpe_pkg::IDX_W-1:0]           row;
   logic [mpe_pkg::IDX_W-1:0]           col;
   logic signed [mpe_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output mode, output row, output col, output value,
                   input ready);
   modport sink (input valid, input mode, input row, input col, input value,
                 output ready);
endinterface

interface mpe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mpe_pkg::IDX_W-1:0]         out_row;
   logic [mpe_pkg::IDX_W-1:0]         out_col;
   logic signed [mpe_pkg::SUM_W-1:0]  sum;
   logic                              last;

   modport source (output valid, output out_row, output out_col, output sum, output last,
                   input ready);
   modport sink (input valid, input out_row, input out_col, input sum, input last,
                 output ready);
endinterface

interface mpe_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mpe_pkg::CSR_IDX_W-1:0]     index;
   logic [mpe_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/mpe_ram.sv @@
module mpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/mpe_cell.sv @@
module mpe_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  mpe_pkg::token_type           tok_in,
   input  logic [mpe_pkg::SUM_W-1:0]    sum_in,
   input  logic [mpe_pkg::SUM_W-1:0]    prod,
   output mpe_pkg::token_type           tok_out,
   output logic [mpe_pkg::SUM_W-1:0]    sum_out
);

   mpe_pkg::token_type             tok_ff;
   logic [mpe_pkg::SUM_W-1:0]      sum_ff;

   // the partial sum meets the product of its own inner index here
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
      sum_ff <= sum_in + prod;
   end

   assign tok_out = tok_ff;
   assign sum_out = sum_ff;

endmodule

@@ sv/matrix_product_engine.sv @@
// element writes: one transfer per cycle while no product is being walked
// product: one multiply-accumulate per cycle through the shared read ports and multiplier,
// while the output fifo has room reserved for the next result to start;
// with inner_dim 1 the four-entry output fifo paces it through that reserved room
// first result passes the operand stage, product stage and cells up to inner_dim into the fifo
// reset: dimension registers to 8, stores read as zero through per-entry valid bits
module matrix_product_engine #(
   parameter int MAX_DIM    = mpe_pkg::MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = mpe_pkg::ELEM_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mpe_req_if.sink    req_if,
   mpe_rsp_if.source  rsp_if,
   mpe_csr_if.sink    csr_if
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(MAX_DIM);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_RUN  = 1'b1;

   function automatic logic [CNT_W-1:0] last_index(input logic [mpe_pkg::CSR_DATA_W-1:0] r);
      if (r == '0) begin
         return '0;
      end else if (int'(r) > MAX_DIM) begin
         return CNT_W'(MAX_DIM - 1);
      end else begin
         return CNT_W'(int'(r) - 1);
      end
   endfunction

   // configuration
   logic [mpe_pkg::CSR_DATA_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [CNT_W-1:0]               nr_m1, nk_m1, nc_m1;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mpe_pkg::DIM_RESET;
         inner_dim_ff <= mpe_pkg::DIM_RESET;
         cols_b_ff    <= mpe_pkg::DIM_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            mpe_pkg::CSR_ROWS_A:    rows_a_ff    <= csr_if.data;
            mpe_pkg::CSR_INNER_DIM: inner_dim_ff <= csr_if.data;
            mpe_pkg::CSR_COLS_B:    cols_b_ff    <= csr_if.data;
            default: ;
         endcase
      end
   end

   assign nr_m1 = last_index(rows_a_ff);
   assign nk_m1 = last_index(inner_dim_ff);
   assign nc_m1 = last_index(cols_b_ff);

   // sequencer
   logic                           state_ff, state_in;
   logic [CNT_W-1:0]               i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [mpe_pkg::FIFO_CNT_W-1:0] pending_ff, pending_in;
   logic                           req_xfer, rsp_xfer, issue, start;
   logic                           wr_ok, wr_a, wr_b;
   logic [ADDR_W-1:0]              wr_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_WIDTH-1:0]          wr_data;

   assign req_if.ready = (state_ff == STATE_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign rsp_xfer     = rsp_if.valid && rsp_if.ready;

   // a new result may start only when the output fifo has room reserved for it
   assign issue = (state_ff == STATE_RUN)
                  && ((k_ff != '0) || (pending_ff < mpe_pkg::FIFO_CNT_W'(mpe_pkg::FIFO_DEPTH)));
   assign start = issue && (k_ff == '0);

   assign wr_ok   = req_xfer && (int'(req_if.row) < MAX_DIM) && (int'(req_if.col) < MAX_DIM);
   assign wr_a    = wr_ok && (req_if.mode == mpe_pkg::MODE_WRITE_A);
   assign wr_b    = wr_ok && (req_if.mode == mpe_pkg::MODE_WRITE_B);
   assign wr_addr = ADDR_W'(int'(req_if.row) * MAX_DIM + int'(req_if.col));
   assign wr_data = ELEM_WIDTH'(req_if.value);

   assign a_rd_addr = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign b_rd_addr = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      if (state_ff == STATE_IDLE) begin
         if (req_xfer && (req_if.mode == mpe_pkg::MODE_COMPUTE)) begin
            state_in = STATE_RUN;
            i_in     = '0;
            j_in     = '0;
            k_in     = '0;
         end
      end else if (issue) begin
         if (k_ff == nk_m1) begin
            k_in = '0;
            if (j_ff == nc_m1) begin
               j_in = '0;
               if (i_ff == nr_m1) begin
                  state_in = STATE_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_comb begin
      pending_in = pending_ff;
      if (start && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (!start && rsp_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STATE_IDLE;
         pending_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   // stores, with valid bits so that unwritten entries read as zero
   logic [DEPTH-1:0]      a_valid_ff, b_valid_ff;
   logic                  a_vld_ff, b_vld_ff;
   logic [ELEM_WIDTH-1:0] a_rd_data, b_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= '0;
         b_valid_ff <= '0;
      end else begin
         if (wr_a) begin
            a_valid_ff[wr_addr] <= 1'b1;
         end
         if (wr_b) begin
            b_valid_ff[wr_addr] <= 1'b1;
         end
      end
      if (issue) begin
         a_vld_ff <= a_valid_ff[a_rd_addr];
         b_vld_ff <= b_valid_ff[b_rd_addr];
      end
   end

   mpe_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mpe_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // operand stage then product stage
   logic                           s1_start_ff, s2_start_ff;
   logic [mpe_pkg::IDX_W-1:0]      s1_row_ff, s1_col_ff, s2_row_ff, s2_col_ff;
   logic                           s1_last_ff, s2_last_ff;
   logic signed [ELEM_WIDTH-1:0]   a_op, b_op;
   logic signed [2*ELEM_WIDTH-1:0] prod_full;
   logic [mpe_pkg::SUM_W-1:0]      prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_start_ff <= 1'b0;
         s2_start_ff <= 1'b0;
      end else begin
         s1_start_ff <= start;
         s2_start_ff <= s1_start_ff;
      end
      s1_row_ff  <= mpe_pkg::IDX_W'(i_ff);
      s1_col_ff  <= mpe_pkg::IDX_W'(j_ff);
      s1_last_ff <= (i_ff == nr_m1) && (j_ff == nc_m1);
      s2_row_ff  <= s1_row_ff;
      s2_col_ff  <= s1_col_ff;
      s2_last_ff <= s1_last_ff;
      prod_ff    <= mpe_pkg::SUM_W'(prod_full);
   end

   assign a_op      = a_vld_ff ? signed'(a_rd_data) : '0;
   assign b_op      = b_vld_ff ? signed'(b_rd_data) : '0;
   assign prod_full = a_op * b_op;

   // chain of accumulate cells, cell k adds the product of inner index k
   mpe_pkg::token_type        head_tok;
   mpe_pkg::token_type        cell_tok [MAX_DIM];
   logic [mpe_pkg::SUM_W-1:0] cell_sum [MAX_DIM];

   assign head_tok = '{valid: s2_start_ff, row: s2_row_ff, col: s2_col_ff, last: s2_last_ff};

   for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
      if (g == 0) begin : g_first
         mpe_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (head_tok),
            .sum_in  ('0),
            .prod    (prod_ff),
            .tok_out (cell_tok[g]),
            .sum_out (cell_sum[g])
         );
      end else begin : g_rest
         mpe_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (cell_tok[g-1]),
            .sum_in  (cell_sum[g-1]),
            .prod    (prod_ff),
            .tok_out (cell_tok[g]),
            .sum_out (cell_sum[g])
         );
      end
   end

   // output fifo
   mpe_pkg::token_type                 res_tok;
   logic                               push;
   mpe_pkg::token_type                 fifo_tok_ff [mpe_pkg::FIFO_DEPTH];
   logic [mpe_pkg::SUM_W-1:0]          fifo_sum_ff [mpe_pkg::FIFO_DEPTH];
   logic [mpe_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [mpe_pkg::FIFO_CNT_W-1:0]     fifo_cnt_ff;

   assign res_tok = cell_tok[nk_m1];
   assign push    = res_tok.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !rsp_xfer) begin
            fifo_cnt_ff <= fifo_cnt_ff + 1'b1;
         end else if (!push && rsp_xfer) begin
            fifo_cnt_ff <= fifo_cnt_ff - 1'b1;
         end
      end
      if (push) begin
         fifo_tok_ff[wr_ptr_ff] <= res_tok;
         fifo_sum_ff[wr_ptr_ff] <= cell_sum[nk_m1];
      end
   end

   assign rsp_if.valid   = (fifo_cnt_ff != '0);
   assign rsp_if.out_row = fifo_tok_ff[rd_ptr_ff].row;
   assign rsp_if.out_col = fifo_tok_ff[rd_ptr_ff].col;
   assign rsp_if.last    = fifo_tok_ff[rd_ptr_ff].last;
   assign rsp_if.sum     = signed'(fifo_sum_ff[rd_ptr_ff]);

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= mpe_pkg::FIFO_CNT_W'(mpe_pkg::FIFO_DEPTH))
      else $error("more results started than the output fifo can hold");

   a_pending_covers_fifo: assert property (@(posedge clock) disable iff (reset)
      pending_ff >= fifo_cnt_ff)
      else $error("fifo holds a result that was never started");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !rsp_xfer |-> fifo_cnt_ff < mpe_pkg::FIFO_CNT_W'(mpe_pkg::FIFO_DEPTH))
      else $error("output fifo overflow");

   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_if.mode == mpe_pkg::MODE_COMPUTE) |=> !req_if.ready)
      else $error("request taken while a product is walking");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int DIM_MAX       = mpe_pkg::MAX_DIM_DEFAULT;
   localparam int OP_TARGET     = 160;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;

   localparam logic [mpe_pkg::CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam logic [mpe_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;

   typedef struct {
      logic [mpe_pkg::MODE_W-1:0]         mode;
      logic [mpe_pkg::IDX_W-1:0]          row;
      logic [mpe_pkg::IDX_W-1:0]          col;
      logic signed [mpe_pkg::VALUE_W-1:0] value;
   } mat_op_type;

   typedef struct {
      logic [mpe_pkg::IDX_W-1:0]        row;
      logic [mpe_pkg::IDX_W-1:0]        col;
      logic signed [mpe_pkg::SUM_W-1:0] sum;
      logic                             last;
   } prod_elem_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mpe_req_if req_bus ();
   mpe_rsp_if rsp_bus ();
   mpe_csr_if csr_bus ();

   matrix_product_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // shadow copy of the block state
   logic signed [mpe_pkg::VALUE_W-1:0] a_mat [DIM_MAX][DIM_MAX];
   logic signed [mpe_pkg::VALUE_W-1:0] b_mat [DIM_MAX][DIM_MAX];
   logic [mpe_pkg::CSR_DATA_W-1:0]     dim_rows  = mpe_pkg::DIM_RESET;
   logic [mpe_pkg::CSR_DATA_W-1:0]     dim_inner = mpe_pkg::DIM_RESET;
   logic [mpe_pkg::CSR_DATA_W-1:0]     dim_cols  = mpe_pkg::DIM_RESET;

   mat_op_type    op_fifo [$];
   prod_elem_type expected_elems [$];

   int  mismatch_cnt = 0;
   int  ops_queued   = 0;
   int  req_wait     = 0;
   int  rsp_wait     = 0;
   int  rsp_hold     = 0;
   int  quiet_cycles = 0;
   bit  req_idle_on  = 1'b1;
   bit  rsp_idle_on  = 1'b1;

   initial begin
      for (int r = 0; r < DIM_MAX; r++) begin
         for (int c = 0; c < DIM_MAX; c++) begin
            a_mat[r][c] = '0;
            b_mat[r][c] = '0;
         end
      end
   end

   function automatic int dim_clamp(logic [mpe_pkg::CSR_DATA_W-1:0] r);
      if (r == 0) return 1;
      if (r > DIM_MAX) return DIM_MAX;
      return int'(r);
   endfunction

   task automatic predict_product();
      int            nr;
      int            nk;
      int            nc;
      longint        acc;
      prod_elem_type e;
      nr = dim_clamp(dim_rows);
      nk = dim_clamp(dim_inner);
      nc = dim_clamp(dim_cols);
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++)
               acc += longint'(a_mat[i][k]) * longint'(b_mat[k][j]);
            e.row  = mpe_pkg::IDX_W'(i);
            e.col  = mpe_pkg::IDX_W'(j);
            e.sum  = acc[mpe_pkg::SUM_W-1:0];
            e.last = (i == nr - 1) && (j == nc - 1);
            expected_elems.push_back(e);
         end
      end
   endtask

   task automatic apply_matrix_op(mat_op_type op);
      case (op.mode)
         mpe_pkg::MODE_WRITE_A: a_mat[op.row][op.col] = op.value;
         mpe_pkg::MODE_WRITE_B: b_mat[op.row][op.col] = op.value;
         mpe_pkg::MODE_COMPUTE: predict_product();
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_matrix_op(op_fifo[0]);
            void'(op_fifo.pop_front());
            req_wait = req_idle_on ? $urandom_range(0, 15) : 0;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the offered item
         end else if (req_wait > 0) begin
            req_wait--;
            req_bus.valid <= 1'b0;
         end else if (op_fifo.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.mode  <= op_fifo[0].mode;
            req_bus.row   <= op_fifo[0].row;
            req_bus.col   <= op_fifo[0].col;
            req_bus.value <= op_fifo[0].value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      prod_elem_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_elems.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected result: row %0d col %0d sum %0d last %0b",
                           rsp_bus.out_row, rsp_bus.out_col, rsp_bus.sum, rsp_bus.last);
            end else begin
               e = expected_elems.pop_front();
               if (rsp_bus.out_row !== e.row || rsp_bus.out_col !== e.col ||
                   rsp_bus.sum !== e.sum || rsp_bus.last !== e.last) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display({"result mismatch: exp row %0d col %0d sum %0d last %0b, ",
                               "got row %0d col %0d sum %0d last %0b"},
                              e.row, e.col, e.sum, e.last, rsp_bus.out_row, rsp_bus.out_col,
                              rsp_bus.sum, rsp_bus.last);
               end
            end
            rsp_wait = rsp_idle_on ? $urandom_range(0, 15) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic signed [mpe_pkg::VALUE_W-1:0] rand_q88();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return mpe_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [mpe_pkg::CSR_DATA_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return mpe_pkg::CSR_DATA_W'($urandom_range(9, 15));
         2: return mpe_pkg::DIM_RESET;
         default: return mpe_pkg::CSR_DATA_W'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic push_op(logic [mpe_pkg::MODE_W-1:0] mode, int row, int col,
                          logic signed [mpe_pkg::VALUE_W-1:0] value);
      mat_op_type op;
      op.mode  = mode;
      op.row   = mpe_pkg::IDX_W'(row);
      op.col   = mpe_pkg::IDX_W'(col);
      op.value = value;
      op_fifo.push_back(op);
      if (mode != MODE_UNUSED) ops_queued++;
   endtask

   task automatic push_noise();
      push_op(mpe_pkg::MODE_W'($urandom_range(0, 3)), $urandom_range(0, 7),
              $urandom_range(0, 7), rand_q88());
   endtask

   task automatic set_dim(logic [mpe_pkg::CSR_IDX_W-1:0] idx,
                          logic [mpe_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      case (idx)
         mpe_pkg::CSR_ROWS_A:    dim_rows  = data;
         mpe_pkg::CSR_INNER_DIM: dim_inner = data;
         mpe_pkg::CSR_COLS_B:    dim_cols  = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // wait until all products are out, then let the block go quiet
   task automatic settle();
      do @(negedge clock); while (op_fifo.size() != 0 || expected_elems.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int nr;
      int nk;
      int nc;
      req_bus.valid = 1'b0;
      req_bus.mode  = mpe_pkg::MODE_WRITE_A;
      req_bus.row   = '0;
      req_bus.col   = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = mpe_pkg::CSR_ROWS_A;
      csr_bus.data  = mpe_pkg::DIM_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // product of the cleared stores, then extreme operands
      push_op(mpe_pkg::MODE_COMPUTE, 0, 0, '0);
      for (int k = 0; k < DIM_MAX; k++) begin
         push_op(mpe_pkg::MODE_WRITE_A, 0, k, 16'sh8000);
         push_op(mpe_pkg::MODE_WRITE_B, k, 0, 16'sh8000);
      end
      push_op(mpe_pkg::MODE_WRITE_A, 7, 7, 16'sh7fff);
      push_op(mpe_pkg::MODE_WRITE_B, 7, 7, 16'sh8000);
      push_op(MODE_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), rand_q88());
      push_op(mpe_pkg::MODE_COMPUTE, 7, 7, '0);
      settle();

      // receiver stalls while a product fills the output fifo and loads wait back to back behind it
      req_idle_on = 1'b0;
      rsp_hold    = HOLD_CYCLES;
      push_op(mpe_pkg::MODE_COMPUTE, 0, 0, '0);
      repeat (20) push_op(mpe_pkg::MODE_W'($urandom_range(0, 1)), $urandom_range(0, 7),
                          $urandom_range(0, 7), rand_q88());
      push_op(mpe_pkg::MODE_COMPUTE, 0, 0, '0);
      settle();
      req_idle_on = 1'b1;

      // zero and oversize dimensions, and the unused register index
      set_dim(mpe_pkg::CSR_ROWS_A, 4'd0);
      set_dim(mpe_pkg::CSR_INNER_DIM, 4'd15);
      set_dim(mpe_pkg::CSR_COLS_B, 4'd1);
      set_dim(CSR_UNUSED, 4'd5);
      push_op(mpe_pkg::MODE_COMPUTE, 0, 0, '0);
      settle();
      set_dim(mpe_pkg::CSR_ROWS_A, 4'd15);
      set_dim(mpe_pkg::CSR_INNER_DIM, 4'd0);
      set_dim(mpe_pkg::CSR_COLS_B, 4'd15);
      push_op(mpe_pkg::MODE_COMPUTE, 0, 0, '0);
      settle();
      set_dim(mpe_pkg::CSR_ROWS_A, 4'd1);
      set_dim(mpe_pkg::CSR_INNER_DIM, 4'd1);
      set_dim(mpe_pkg::CSR_COLS_B, 4'd1);
      push_op(mpe_pkg::MODE_COMPUTE, 0, 0, '0);
      settle();

      while (ops_queued < OP_TARGET) begin
         set_dim(mpe_pkg::CSR_ROWS_A, pick_dim());
         set_dim(mpe_pkg::CSR_INNER_DIM, pick_dim());
         set_dim(mpe_pkg::CSR_COLS_B, pick_dim());
         if ($urandom_range(0, 4) == 0) set_dim(CSR_UNUSED, mpe_pkg::CSR_DATA_W'($urandom));
         req_idle_on = $urandom_range(0, 2) != 0;
         rsp_idle_on = $urandom_range(0, 2) != 0;
         nr = dim_clamp(dim_rows);
         nk = dim_clamp(dim_inner);
         nc = dim_clamp(dim_cols);
         // load the active region, sparsely when it is big
         for (int i = 0; i < nr; i++)
            for (int k = 0; k < nk; k++)
               if (nr * nk <= 9 || $urandom_range(0, 3) == 0)
                  push_op(mpe_pkg::MODE_WRITE_A, i, k, rand_q88());
         for (int k = 0; k < nk; k++)
            for (int j = 0; j < nc; j++)
               if (nk * nc <= 9 || $urandom_range(0, 3) == 0)
                  push_op(mpe_pkg::MODE_WRITE_B, k, j, rand_q88());
         repeat ($urandom_range(0, 3)) push_noise();
         push_op(mpe_pkg::MODE_COMPUTE, 0, 0, '0);
         if ($urandom_range(0, 3) == 0) begin
            push_noise();
            push_op(mpe_pkg::MODE_COMPUTE, 0, 0, '0);
         end
         settle();
      end

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      settle();
      mismatch_cnt += expected_elems.size();
      if (mismatch_cnt == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
